// File: rtl/core/lsb_sfd_pkg.sv
// Shared types, constants and codes of the LSB steganography frame decoder.
package lsb_sfd_pkg;

  // Image header length and field bounds.
  localparam int unsigned HEADER_BYTES  = 54;
  localparam int unsigned MAGIC_MAX_LEN = 8;
  localparam int unsigned EXTN_MAX_LEN  = 8;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC      = 2'd0,
    CFG_MAGIC_LEN  = 2'd1,
    CFG_SIZE_LIMIT = 2'd2
  } cfg_idx_e;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGLEN  = 3'd1,
    PH_MAGIC   = 3'd2,
    PH_EXTLEN  = 3'd3,
    PH_EXT     = 3'd4,
    PH_DATALEN = 3'd5,
    PH_DATA    = 3'd6
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MAGLEN = 3'd1,
    ST_MAGIC  = 3'd2,
    ST_EXTLEN = 3'd3,
    ST_SIZE   = 3'd4,
    ST_TRUNC  = 3'd5
  } status_e;

  // Kinds of result byte.
  typedef enum logic [1:0] {
    KIND_EXT  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  // Configuration registers as seen by the decode logic.
  typedef struct packed {
    logic [63:0] magic;
    logic [3:0]  magic_len;
    logic [30:0] size_limit;
  } cfg_t;

  // Frame decoder state carried from one request to the next.
  typedef struct packed {
    phase_e      phase;
    logic [5:0]  header_cnt;
    logic [4:0]  bit_cnt;
    logic [31:0] acc;
    logic [30:0] remaining;
    logic [63:0] magic_rx;
    logic [3:0]  magic_len;
    logic        halted;
  } dec_state_t;

  // One decode result; emit says whether it leaves the block.
  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    kind_e      kind;
    logic       final_res;
    status_e    status;
  } result_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    phase:      PH_HEADER,
    header_cnt: 6'd0,
    bit_cnt:    5'd0,
    acc:        32'd0,
    remaining:  31'd0,
    magic_rx:   64'd0,
    magic_len:  4'd0,
    halted:     1'b0
  };

  localparam logic [63:0] MAGIC_RESET      = 64'd0;
  localparam logic [3:0]  MAGIC_LEN_RESET  = 4'd0;
  localparam logic [30:0] SIZE_LIMIT_RESET = 31'd65536;

endpackage

// File: rtl/core/lsb_sfd_if.sv
// Valid/ready channel interfaces for image bytes in and decoded bytes out.
interface lsb_sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output pixel_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input pixel_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface lsb_sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       final_res;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_kind, output final_res,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input final_res,
                  input status, output ready);
endinterface

// File: rtl/core/lsb_stego_frame_decoder_unit.sv
// Top level of the LSB steganography frame decoder: request staging, state, config, results.
// Results are registered: an accepted image byte is held in the input register, decoded, and its
// result is loaded into the result register when that register is free or being drained.
// Throughput: one image byte per cycle; the single decode stage between the input register
// and the result register sets this, and stalls only when the result register is held.
// Reset: asynchronous, active low; decoder state returns to the header phase and the
// registers take their reset values (magic 0, magic length 0, data size limit 65536).
module lsb_stego_frame_decoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  lsb_sfd_in_if.sink                            in_i,
  lsb_sfd_out_if.source                         out_o,
  input  logic                                  cfg_we_i,
  input  logic [lsb_sfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsb_sfd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lsb_sfd_pkg::*;

  cfg_t       cfg_q;
  dec_state_t state_q;
  dec_state_t state_d;
  result_t    res;

  logic       s1_valid_q;
  logic [7:0] s1_pixel_q;
  logic       s1_first_q;
  logic       s1_last_q;
  logic       advance;
  logic       in_take;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  kind_e      out_kind_q;
  logic       out_final_q;
  status_e    out_status_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= MAGIC_RESET;
      cfg_q.magic_len  <= MAGIC_LEN_RESET;
      cfg_q.size_limit <= SIZE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC:      cfg_q.magic      <= cfg_data_i;
        CFG_MAGIC_LEN:  cfg_q.magic_len  <= cfg_data_i[3:0];
        CFG_SIZE_LIMIT: cfg_q.size_limit <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // The staged request moves on whenever the result register is free or being drained.
  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pixel_q <= in_i.pixel_byte;
      s1_first_q <= in_i.first_byte;
      s1_last_q  <= in_i.last_byte;
    end
  end

  // Decode step.
  lsb_sfd_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .pixel_byte_i (s1_pixel_q),
    .first_byte_i (s1_first_q),
    .last_byte_i  (s1_last_q),
    .state_o      (state_d),
    .res_o        (res)
  );

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DEC_STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_byte_q   <= res.out_byte;
      out_kind_q   <= res.kind;
      out_final_q  <= res.final_res;
      out_status_q <= res.status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.byte_kind = out_kind_q;
  assign out_o.final_res = out_final_q;
  assign out_o.status    = out_status_q;

  // A result without a byte always carries a zero byte.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KIND_NONE |-> out_byte_q == 8'd0)
    else $error("result without a byte carries a nonzero byte");

  // A final result is always a clean completion.
  a_final_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_final_q |-> out_status_q == ST_OK)
    else $error("final result with error status");

  // Format errors never carry a byte; only truncation may.
  a_err_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK && out_status_q != ST_TRUNC
      |-> out_kind_q == KIND_NONE)
    else $error("format error result carries a byte");

  // A completion or error halts the decoder.
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.emit && (res.final_res || res.status != ST_OK) |=> state_q.halted)
    else $error("decoder not halted after completion or error");

  // An accepted request is always staged.
  a_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted request lost");

endmodule

// File: rtl/core/lsb_sfd_step.sv
// Combinational decode of one image byte: next decoder state and optional result.
module lsb_sfd_step (
  input  lsb_sfd_pkg::cfg_t       cfg_i,
  input  lsb_sfd_pkg::dec_state_t state_i,
  input  logic [7:0]              pixel_byte_i,
  input  logic                    first_byte_i,
  input  logic                    last_byte_i,
  output lsb_sfd_pkg::dec_state_t state_o,
  output lsb_sfd_pkg::result_t    res_o
);
  import lsb_sfd_pkg::*;

  dec_state_t  cur;
  dec_state_t  nxt;
  result_t     res;
  phase_e      ph;
  logic [31:0] val;
  logic [7:0]  new_byte;
  logic [30:0] rem;
  logic [2:0]  idx;
  logic [63:0] mrx;
  logic [63:0] mask;

  // Byte mask of the expected magic: byte i counts when i is below the length.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < cfg_i.magic_len) ? 8'hFF : 8'h00;
    end
  end

  // Skip the header bytes, then fold the LSB of each byte into the current field and advance the phase.
  always_comb begin
    cur      = first_byte_i ? DEC_STATE_RESET : state_i;
    nxt      = cur;
    res      = '{emit: 1'b0, out_byte: 8'd0, kind: KIND_NONE, final_res: 1'b0,
                 status: ST_OK};
    ph       = (cur.phase == PH_HEADER) ? PH_MAGLEN : cur.phase;
    val      = cur.acc | (32'(pixel_byte_i[0]) << cur.bit_cnt);
    new_byte = val[7:0];
    rem      = (cur.remaining != 31'd0) ? cur.remaining - 31'd1 : 31'd0;
    idx      = cur.magic_len[2:0] - 3'd1 - rem[2:0];
    mrx      = cur.magic_rx | (64'(new_byte) << {idx, 3'b000});

    if (!cur.halted) begin
      if (cur.phase == PH_HEADER && cur.header_cnt < 6'(HEADER_BYTES)) begin
        nxt.header_cnt = cur.header_cnt + 6'd1;
      end else begin
        nxt.phase = ph;
        nxt.acc   = val;
        if (ph == PH_MAGLEN || ph == PH_EXTLEN || ph == PH_DATALEN) begin
          // 32-bit length fields.
          if (cur.bit_cnt != 5'd31) begin
            nxt.bit_cnt = cur.bit_cnt + 5'd1;
          end else begin
            nxt.acc     = 32'd0;
            nxt.bit_cnt = 5'd0;
            if (ph == PH_MAGLEN) begin
              if (val > 32'(MAGIC_MAX_LEN)) begin
                res.status = ST_MAGLEN;
              end else begin
                nxt.magic_len = val[3:0];
                nxt.remaining = val[30:0];
                nxt.magic_rx  = 64'd0;
                if (val == 32'd0) begin
                  // An empty magic matches only an empty expected magic.
                  if (cfg_i.magic_len != 4'd0) begin
                    res.status = ST_MAGIC;
                  end else begin
                    nxt.phase = PH_EXTLEN;
                  end
                end else begin
                  nxt.phase = PH_MAGIC;
                end
              end
            end else if (ph == PH_EXTLEN) begin
              if (val > 32'(EXTN_MAX_LEN)) begin
                res.status = ST_EXTLEN;
              end else if (val == 32'd0) begin
                nxt.phase = PH_DATALEN;
              end else begin
                nxt.remaining = val[30:0];
                nxt.phase     = PH_EXT;
              end
            end else begin
              if (val >= 32'(cfg_i.size_limit)) begin
                res.status = ST_SIZE;
              end else if (val == 32'd0) begin
                res.emit      = 1'b1;
                res.final_res = 1'b1;
                nxt.halted    = 1'b1;
              end else begin
                nxt.remaining = val[30:0];
                nxt.phase     = PH_DATA;
              end
            end
          end
        end else begin
          // Byte fields: magic, extension and data.
          if (cur.bit_cnt != 5'd7) begin
            nxt.bit_cnt = cur.bit_cnt + 5'd1;
          end else begin
            nxt.acc       = 32'd0;
            nxt.bit_cnt   = 5'd0;
            nxt.remaining = rem;
            if (ph == PH_MAGIC) begin
              nxt.magic_rx = mrx;
              if (rem == 31'd0) begin
                if (cfg_i.magic_len != cur.magic_len ||
                    ((mrx ^ cfg_i.magic) & mask) != 64'd0) begin
                  res.status = ST_MAGIC;
                end else begin
                  nxt.phase = PH_EXTLEN;
                end
              end
            end else if (ph == PH_EXT) begin
              res.emit     = 1'b1;
              res.out_byte = new_byte;
              res.kind     = KIND_EXT;
              if (rem == 31'd0) begin
                nxt.phase = PH_DATALEN;
              end
            end else begin
              res.emit     = 1'b1;
              res.out_byte = new_byte;
              res.kind     = KIND_DATA;
              if (rem == 31'd0) begin
                res.final_res = 1'b1;
                nxt.halted    = 1'b1;
              end
            end
          end
        end
      end

      // Errors halt; otherwise an early end of image reports truncation.
      if (res.status != ST_OK) begin
        res.emit   = 1'b1;
        nxt.halted = 1'b1;
      end else if (last_byte_i && !nxt.halted) begin
        res.status = ST_TRUNC;
        res.emit   = 1'b1;
        nxt.halted = 1'b1;
      end
    end
  end

  assign state_o = nxt;
  assign res_o   = res;

endmodule
